>>> hdl/tgac_pkg.sv
`default_nettype none

package tgac_pkg;

   localparam int OUT_W      = 32;
   localparam int GAP_W      = 16;
   localparam int LIM_W      = 32;
   localparam int RATE_W     = 10;
   localparam int AXIS_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MIN_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_MAX   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_RATE  = 2'd3;

   localparam logic [AXIS_W-1:0] AXIS_SELECT_RESET = AXIS_X;
   localparam logic [GAP_W-1:0]  GAP_MIN_LEN_RESET = 16'd0;
   localparam logic [LIM_W-1:0]  ACCEL_MAX_RESET   = 32'hFFFF_FFFF;
   localparam logic [RATE_W-1:0] FRAME_RATE_RESET  = 10'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_SAVE,
      ST_MAG,
      ST_PROD,
      ST_ACCUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic start;
      logic load_div;
      logic div_step;
      logic store_v1;
      logic make_mag;
      logic make_prod;
      logic accum;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic check_en;
      logic div_last;
      logic second_vel;
      logic last_axis;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [AXIS_W-1:0] axis_select;
      logic [GAP_W-1:0]  gap_min_len;
      logic [LIM_W-1:0]  accel_max;
      logic [RATE_W-1:0] frame_rate;
   } cfg_type;

endpackage

`default_nettype wire

>>> hdl/tgac_ctrl.sv
`default_nettype none

module tgac_ctrl import tgac_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.start = 1'b1;
            state_in  = status.check_en ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            cmd.load_div = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = status.second_vel ? ST_MAG : ST_SAVE;
            end
         end
         ST_SAVE: begin
            cmd.store_v1 = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MAG: begin
            cmd.make_mag = 1'b1;
            state_in     = ST_PROD;
         end
         ST_PROD: begin
            cmd.make_prod = 1'b1;
            state_in      = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = status.last_axis ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/tgac_dp.sv
`default_nettype none

module tgac_dp import tgac_pkg::*; #(
   parameter int FRAME_BITS = 32,
   parameter int POS_BITS   = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cfg_type                    cfg,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   input  wire logic signed [POS_BITS-1:0] req_pos_x,
   input  wire logic signed [POS_BITS-1:0] req_pos_y,
   input  wire logic signed [POS_BITS-1:0] req_pos_z,
   input  wire logic                       req_miss_x,
   input  wire logic                       req_miss_y,
   input  wire logic                       req_miss_z,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [OUT_W-1:0]                rsp_frame_index,
   output logic                            rsp_gap_closed,
   output logic [OUT_W-1:0]                rsp_gap_first_frame,
   output logic                            rsp_accel_error,
   output logic [OUT_W-1:0]                rsp_accel_error_frame,
   output logic                            rsp_gap_open
);

   localparam int NUM_W  = POS_BITS + RATE_W;
   localparam int VEL_W  = NUM_W + 1;
   localparam int DIFF_W = NUM_W + 2;
   localparam int MAG_W  = NUM_W + 1;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int CMP_W  = (FRAME_BITS > GAP_W) ? FRAME_BITS : GAP_W;
   localparam int OVC_W  = (MAG_W > LIM_W) ? MAG_W : LIM_W;
   localparam int SQ_W   = 2 * LIM_W;
   localparam int SUM_W  = SQ_W + 2;

   logic signed [POS_BITS-1:0] pos_ff   [3];
   logic signed [POS_BITS-1:0] last_ff  [3];
   logic signed [POS_BITS-1:0] prior_ff [3];
   logic [2:0]                 miss_ff;
   logic [FRAME_BITS-1:0]      frame_ff;
   logic [FRAME_BITS-1:0]      frame_counter_ff;
   logic                       gap_active_ff;
   logic [FRAME_BITS-1:0]      gap_start_ff;
   logic [FRAME_BITS-1:0]      last_vf_ff;
   logic [FRAME_BITS-1:0]      prior_vf_ff;
   logic [1:0]                 valid_hist_ff;
   logic [1:0]                 taint_hist_ff;
   logic [AXIS_W-1:0]          axis_ff;
   logic                       second_ff;
   logic [NUM_W-1:0]           quo_ff;
   logic [FRAME_BITS-1:0]      rem_ff;
   logic [FRAME_BITS-1:0]      den_ff;
   logic                       neg_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic signed [VEL_W-1:0]    v1_ff;
   logic [MAG_W-1:0]           m_ff;
   logic [SQ_W-1:0]            prod_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic                       over_ff;
   logic [SQ_W-1:0]            limsq_ff;
   logic                       chk_ff;
   logic                       rsp_valid_ff;
   logic [OUT_W-1:0]           rsp_frame_index_ff;
   logic                       rsp_gap_closed_ff;
   logic [OUT_W-1:0]           rsp_gap_first_frame_ff;
   logic                       rsp_accel_error_ff;
   logic [OUT_W-1:0]           rsp_accel_error_frame_ff;
   logic                       rsp_gap_open_ff;

   logic                       absent;
   logic                       tainted;
   logic signed [POS_BITS-1:0] pos_sel;
   logic signed [POS_BITS-1:0] last_sel;
   logic signed [POS_BITS-1:0] prior_sel;
   logic signed [POS_BITS-1:0] op_a;
   logic signed [POS_BITS-1:0] op_b;
   logic signed [POS_BITS:0]   dpos;
   logic [POS_BITS:0]          dmag;
   logic [NUM_W-1:0]           num;
   logic [FRAME_BITS-1:0]      frame_dist;
   logic [FRAME_BITS:0]        trial;
   logic [FRAME_BITS:0]        trial_sub;
   logic                       trial_ge;
   logic signed [VEL_W-1:0]    vel;
   logic signed [DIFF_W-1:0]   vdiff;
   logic [DIFF_W-1:0]          vabs;
   logic [LIM_W-1:0]           m_lo;
   logic                       exceed;
   logic                       out_free;
   logic                       gap_long;

   always_comb begin
      unique case (cfg.axis_select)
         AXIS_X:  absent = miss_ff[0];
         AXIS_Y:  absent = miss_ff[1];
         default: absent = miss_ff[2];
      endcase
   end

   assign tainted = |miss_ff;

   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            pos_sel   = pos_ff[0];
            last_sel  = last_ff[0];
            prior_sel = prior_ff[0];
         end
         AXIS_Y: begin
            pos_sel   = pos_ff[1];
            last_sel  = last_ff[1];
            prior_sel = prior_ff[1];
         end
         default: begin
            pos_sel   = pos_ff[2];
            last_sel  = last_ff[2];
            prior_sel = prior_ff[2];
         end
      endcase
   end

   assign op_a      = second_ff ? last_sel : pos_sel;
   assign op_b      = second_ff ? prior_sel : last_sel;
   assign dpos      = {op_a[POS_BITS-1], op_a} - {op_b[POS_BITS-1], op_b};
   assign dmag      = dpos[POS_BITS] ? (~dpos + 1'b1) : dpos;
   assign num       = NUM_W'(dmag[POS_BITS-1:0]) * NUM_W'(cfg.frame_rate);
   assign frame_dist = second_ff ? (last_vf_ff - prior_vf_ff) : (frame_ff - last_vf_ff);

   assign trial     = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign trial_ge  = (trial >= {1'b0, den_ff});

   assign vel       = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign vdiff     = {v1_ff[VEL_W-1], v1_ff} - {vel[VEL_W-1], vel};
   assign vabs      = vdiff[DIFF_W-1] ? (~vdiff + 1'b1) : vdiff;
   assign m_lo      = LIM_W'(m_ff);

   assign exceed    = over_ff || (sum_ff > SUM_W'(limsq_ff));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign gap_long  = CMP_W'(frame_ff - gap_start_ff) > CMP_W'(cfg.gap_min_len);

   assign status.check_en   = !absent && !tainted && (valid_hist_ff == 2'b11)
                              && (taint_hist_ff == 2'b00);
   assign status.div_last   = (cnt_ff == CNT_W'(NUM_W - 1));
   assign status.second_vel = second_ff;
   assign status.last_axis  = (axis_ff == AXIS_Z);
   assign status.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_counter_ff <= '0;
         gap_active_ff    <= 1'b0;
         gap_start_ff     <= '0;
         last_vf_ff       <= '0;
         prior_vf_ff      <= '0;
         valid_hist_ff    <= '0;
         taint_hist_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            last_ff[i]  <= '0;
            prior_ff[i] <= '0;
         end
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.commit) begin
            if (!(&frame_ff)) begin
               frame_counter_ff <= frame_ff + 1'b1;
            end
            if (absent) begin
               if (!gap_active_ff) begin
                  gap_active_ff <= 1'b1;
                  gap_start_ff  <= frame_ff;
               end
            end else begin
               gap_active_ff <= 1'b0;
               prior_vf_ff   <= last_vf_ff;
               last_vf_ff    <= frame_ff;
               valid_hist_ff <= {valid_hist_ff[0], 1'b1};
               taint_hist_ff <= {taint_hist_ff[0], tainted};
               for (int i = 0; i < 3; i++) begin
                  prior_ff[i] <= last_ff[i];
                  last_ff[i]  <= pos_ff[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
         miss_ff   <= {req_miss_z, req_miss_y, req_miss_x};
         frame_ff  <= frame_counter_ff;
      end
      if (cmd.start) begin
         axis_ff   <= AXIS_X;
         second_ff <= 1'b0;
         sum_ff    <= '0;
         over_ff   <= 1'b0;
         chk_ff    <= status.check_en;
         limsq_ff  <= SQ_W'(cfg.accel_max) * SQ_W'(cfg.accel_max);
      end
      if (cmd.load_div) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= (frame_dist == '0) ? FRAME_BITS'(1) : frame_dist;
         neg_ff <= dpos[POS_BITS];
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[NUM_W-2:0], trial_ge};
         rem_ff <= trial_ge ? trial_sub[FRAME_BITS-1:0] : trial[FRAME_BITS-1:0];
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.store_v1) begin
         v1_ff     <= vel;
         second_ff <= 1'b1;
      end
      if (cmd.make_mag) begin
         m_ff <= vabs[DIFF_W-1:1];
      end
      if (cmd.make_prod) begin
         prod_ff <= SQ_W'(m_lo) * SQ_W'(m_lo);
      end
      if (cmd.accum) begin
         sum_ff    <= sum_ff + SUM_W'(prod_ff);
         over_ff   <= over_ff || (OVC_W'(m_ff) > OVC_W'(cfg.accel_max));
         axis_ff   <= axis_ff + 1'b1;
         second_ff <= 1'b0;
      end
      if (cmd.commit) begin
         rsp_frame_index_ff       <= OUT_W'(frame_ff);
         rsp_gap_closed_ff        <= !absent && gap_active_ff && gap_long;
         rsp_gap_first_frame_ff   <= (!absent && gap_active_ff && gap_long) ?
                                     OUT_W'(gap_start_ff) : '0;
         rsp_accel_error_ff       <= !absent && chk_ff && exceed;
         rsp_accel_error_frame_ff <= (!absent && chk_ff && exceed) ?
                                     OUT_W'(last_vf_ff) : '0;
         rsp_gap_open_ff          <= absent;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_index       = rsp_frame_index_ff;
   assign rsp_gap_closed        = rsp_gap_closed_ff;
   assign rsp_gap_first_frame   = rsp_gap_first_frame_ff;
   assign rsp_accel_error       = rsp_accel_error_ff;
   assign rsp_accel_error_frame = rsp_accel_error_frame_ff;
   assign rsp_gap_open          = rsp_gap_open_ff;

`ifndef NO_ASSERTIONS
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("result written over an item not yet taken");

   a_frame_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !(&frame_ff)) |=> frame_counter_ff == $past(frame_ff) + 1'b1)
      else $error("frame counter did not advance");

   a_gap_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_gap_closed_ff) |-> !rsp_gap_open_ff)
      else $error("gap closed and open together");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_div |=> den_ff != '0)
      else $error("divider loaded with zero distance");
`endif

endmodule

`default_nettype wire

>>> hdl/track_gap_and_accel_check.sv
// Flow: one item at a time; req_stall stays high from acceptance until the result is
//   committed, and the commit waits while rsp_stall holds back the previous result.
// Check: when the acceleration check runs, each item uses the shared one-bit-per-cycle
//   divider six times, twice per axis.
// Reset: synchronous active-high; clears frame counter, gap and sample history,
//   and loads the register defaults. No clearing pass.
`default_nettype none

module track_gap_and_accel_check import tgac_pkg::*; #(
   parameter int FRAME_BITS = 32,
   parameter int POS_BITS   = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [POS_BITS-1:0] req_pos_x,
   input  wire logic signed [POS_BITS-1:0] req_pos_y,
   input  wire logic signed [POS_BITS-1:0] req_pos_z,
   input  wire logic                       req_miss_x,
   input  wire logic                       req_miss_y,
   input  wire logic                       req_miss_z,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [OUT_W-1:0]                rsp_frame_index,
   output logic                            rsp_gap_closed,
   output logic [OUT_W-1:0]                rsp_gap_first_frame,
   output logic                            rsp_accel_error,
   output logic [OUT_W-1:0]                rsp_accel_error_frame,
   output logic                            rsp_gap_open,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_select <= AXIS_SELECT_RESET;
         cfg_ff.gap_min_len <= GAP_MIN_LEN_RESET;
         cfg_ff.accel_max   <= ACCEL_MAX_RESET;
         cfg_ff.frame_rate  <= FRAME_RATE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_AXIS_SELECT: cfg_ff.axis_select <= csr_wdata[AXIS_W-1:0];
            CSR_GAP_MIN_LEN: cfg_ff.gap_min_len <= csr_wdata[GAP_W-1:0];
            CSR_ACCEL_MAX:   cfg_ff.accel_max   <= csr_wdata[LIM_W-1:0];
            CSR_FRAME_RATE:  cfg_ff.frame_rate  <= csr_wdata[RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tgac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tgac_dp #(
      .FRAME_BITS (FRAME_BITS),
      .POS_BITS   (POS_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .cmd                   (cmd),
      .status                (status),
      .req_pos_x             (req_pos_x),
      .req_pos_y             (req_pos_y),
      .req_pos_z             (req_pos_z),
      .req_miss_x            (req_miss_x),
      .req_miss_y            (req_miss_y),
      .req_miss_z            (req_miss_z),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_frame_index       (rsp_frame_index),
      .rsp_gap_closed        (rsp_gap_closed),
      .rsp_gap_first_frame   (rsp_gap_first_frame),
      .rsp_accel_error       (rsp_accel_error),
      .rsp_accel_error_frame (rsp_accel_error_frame),
      .rsp_gap_open          (rsp_gap_open)
   );

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
   import tgac_pkg::*;

   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic               mx, my, mz;
   } sample_type;

   typedef struct packed {
      logic [OUT_W-1:0] frame_index;
      logic             gap_closed;
      logic [OUT_W-1:0] gap_first_frame;
      logic             accel_error;
      logic [OUT_W-1:0] accel_error_frame;
      logic             gap_open;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic req_miss_x = 1'b0, req_miss_y = 1'b0, req_miss_z = 1'b0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [OUT_W-1:0] rsp_frame_index, rsp_gap_first_frame, rsp_accel_error_frame;
   logic rsp_gap_closed, rsp_accel_error, rsp_gap_open;
   logic csr_valid = 1'b0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_AXIS_SELECT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   track_gap_and_accel_check DUT (.*);

   always #6 clock = ~clock;

   sample_type  frame_q[$];
   verdict_type verdict_q[$];
   int       mismatches = 0;
   int       cycles = 0;
   int       req_gap = 0, stall_left = 0;
   logic     req_taken = 1'b0;
   logic     calm = 1'b0;

   logic [AXIS_W-1:0] cf_axis;
   logic [GAP_W-1:0]  cf_gap_len;
   logic [LIM_W-1:0]  cf_limit;
   logic [RATE_W-1:0] cf_rate;

   logic [31:0] frame_cnt, run_start, last_vf, prior_vf;
   logic        in_gap;
   longint      last_p[3], prior_p[3];
   logic [1:0]  held_hist, taint_hist;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint scaled_velocity(longint d, longint unsigned n);
      longint unsigned m, q;
      if (n == 0) n = 1;
      m = (d < 0) ? -d : d;
      q = (m * cf_rate) / n;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic too_fast(longint c[3], logic [31:0] frame);
      logic [127:0] total, mm, lim;
      longint v1, v2, a;
      total = '0;
      for (int i = 0; i < 3; i++) begin
         v1 = scaled_velocity(c[i] - last_p[i], longint'(frame) - longint'(last_vf));
         v2 = scaled_velocity(last_p[i] - prior_p[i], longint'(last_vf) - longint'(prior_vf));
         a  = (v1 - v2) / 2;
         mm = (a < 0) ? -a : a;
         total += mm * mm;
      end
      lim = cf_limit;
      return total > lim * lim;
   endfunction

   function automatic verdict_type track_frame(sample_type s);
      verdict_type v;
      longint c[3];
      logic miss[3];
      logic absent, taint;
      int sel;
      v = '{frame_cnt, 1'b0, '0, 1'b0, '0, 1'b0};
      c = '{longint'(s.px), longint'(s.py), longint'(s.pz)};
      miss = '{s.mx, s.my, s.mz};
      sel = (cf_axis > 2) ? 2 : int'(cf_axis);
      absent = miss[sel];
      taint = s.mx | s.my | s.mz;
      if (absent) begin
         if (!in_gap) begin
            in_gap = 1'b1;
            run_start = frame_cnt;
         end
      end else begin
         if (in_gap) begin
            if (frame_cnt - run_start > cf_gap_len) begin
               v.gap_closed = 1'b1;
               v.gap_first_frame = run_start;
            end
            in_gap = 1'b0;
         end
         if (held_hist == 2'b11 && taint_hist == 2'b00 && !taint
               && too_fast(c, frame_cnt)) begin
            v.accel_error = 1'b1;
            v.accel_error_frame = last_vf;
         end
         prior_vf = last_vf;
         last_vf = frame_cnt;
         for (int i = 0; i < 3; i++) begin
            prior_p[i] = last_p[i];
            last_p[i] = c[i];
         end
         held_hist = {held_hist[0], 1'b1};
         taint_hist = {taint_hist[0], taint};
      end
      if (frame_cnt != 32'hFFFF_FFFF) frame_cnt = frame_cnt + 1;
      v.gap_open = in_gap;
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type want, got, due;
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            due = track_frame('{req_pos_x, req_pos_y, req_pos_z,
                                req_miss_x, req_miss_y, req_miss_z});
            verdict_q = {verdict_q, due};
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_frame_index, rsp_gap_closed, rsp_gap_first_frame,
                    rsp_accel_error, rsp_accel_error_frame, rsp_gap_open};
            if (verdict_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item: %p", got);
            end else begin
               want = verdict_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (frame_q.size() > 0) begin
            sample_type s;
            s = frame_q.pop_front();
            {req_pos_x, req_pos_y, req_pos_z} <= {s.px, s.py, s.pz};
            {req_miss_x, req_miss_y, req_miss_z} <= {s.mx, s.my, s.mz};
            req_valid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_AXIS_SELECT: cf_axis    = data[AXIS_W-1:0];
         CSR_GAP_MIN_LEN: cf_gap_len = data[GAP_W-1:0];
         CSR_ACCEL_MAX:   cf_limit   = data[LIM_W-1:0];
         CSR_FRAME_RATE:  cf_rate    = data[RATE_W-1:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int axis, int gap_len, logic [31:0] limit, int rate);
      write_csr(CSR_AXIS_SELECT, axis);
      write_csr(CSR_GAP_MIN_LEN, gap_len);
      write_csr(CSR_ACCEL_MAX, limit);
      write_csr(CSR_FRAME_RATE, rate);
   endtask

   task automatic add(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [2:0] m);
      sample_type s;
      s = '{x, y, z, m[0], m[1], m[2]};
      frame_q = {frame_q, s};
   endtask

   task automatic drain();
      do @(posedge clock);
      while (frame_q.size() != 0 || req_valid || verdict_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_random(int n);
      logic [31:0] base[3], step[3];
      int run_left;
      logic [2:0] m;
      run_left = 0;
      for (int i = 0; i < 3; i++) begin
         base[i] = $urandom();
         step[i] = $urandom_range(0, 1 << 18) - (1 << 17);
      end
      for (int k = 0; k < n; k++) begin
         int r;
         r = $urandom_range(0, 99);
         if (run_left > 0) begin
            run_left--;
            m = 3'b111;
            add($urandom(), $urandom(), $urandom(), m);
         end else if (r < 70) begin
            for (int i = 0; i < 3; i++) begin
               if ($urandom_range(0, 9) == 0) step[i] = $urandom_range(0, 1 << 20) - (1 << 19);
               base[i] = base[i] + step[i] + $urandom_range(0, 255) - 128;
            end
            m = ($urandom_range(0, 19) == 0) ? 3'($urandom()) : 3'b000;
            add(base[0], base[1], base[2], m);
         end else if (r < 85) begin
            add($urandom(), $urandom(), $urandom(), 3'($urandom()));
         end else begin
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            add($urandom(), $urandom(), $urandom(), 3'b111);
         end
      end
   endtask

   initial begin
      cf_axis = AXIS_SELECT_RESET;
      cf_gap_len = GAP_MIN_LEN_RESET;
      cf_limit = ACCEL_MAX_RESET;
      cf_rate = FRAME_RATE_RESET;
      frame_cnt = '0; run_start = '0; last_vf = '0; prior_vf = '0;
      in_gap = 1'b0; held_hist = '0; taint_hist = '0;
      for (int i = 0; i < 3; i++) begin
         last_p[i] = 0;
         prior_p[i] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults first: short gaps, extremes, tainted and absent samples
      add(32'h7FFF_FFFF, 32'h8000_0000, 0, 3'b000);
      add(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'b000);
      add(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 3'b000);
      add(0, 0, 0, 3'b001);
      add(5, 5, 5, 3'b000);
      add(6, 6, 6, 3'b110);
      add(7, 7, 7, 3'b000);
      add(8, 8, 8, 3'b000);
      add(9, 9, 9, 3'b000);
      drain();
      configure(3, 2, 0, 1023);
      add(1, 2, 3, 3'b100);
      add(1, 2, 3, 3'b100);
      add(1, 2, 3, 3'b000);
      add(1, 2, 3, 3'b100);
      add(1, 2, 3, 3'b100);
      add(1, 2, 3, 3'b100);
      add(10, 20, 30, 3'b000);
      add(11, 20, 30, 3'b000);
      add(13, 20, 30, 3'b000);
      drain();
      configure(AXIS_Y, 0, 32'hFFFF_FFFF, 1);
      add(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'b010);
      add(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'b000);
      add(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'b000);
      add(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'b000);
      drain();

      for (int p = 0; p < 8; p++) begin
         logic [31:0] lim;
         int r;
         r = $urandom_range(0, 3);
         lim = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 1 << 28);
         calm = (p % 3 == 2);
         configure($urandom_range(0, 3),
                   (p == 5) ? 65535 : $urandom_range(0, 5),
                   lim,
                   (p == 1) ? 1 : (p == 4) ? 1023 : $urandom_range(1, 1023));
         add_random(150);
         drain();
      end
      calm = 1'b0;

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
